[src/fpa_pkg.sv]
// Shared types and constants for the fixed-point atan2 core.
package fpa_pkg;
  localparam int unsigned QW = 16;
  localparam int unsigned RW = 17;
  localparam int unsigned DEN_W = 17;
  localparam logic signed [15:0] OFFSET_POS = 16'sd1608;
  localparam logic signed [15:0] OFFSET_NEG = 16'sd4824;
  localparam logic signed [7:0] COEF_LIN = -8'sd63;
  localparam logic signed [7:0] COEF_CUB = 8'sd13;

  typedef struct packed {
    logic        last;
    logic        zero;
    logic        x_neg;
    logic        y_neg;
    logic        q_neg;
  } fpa_ctl_t;

  // one restoring-division cell's payload
  typedef struct packed {
    fpa_ctl_t    ctl;
    logic [DEN_W-1:0] den;
    logic [DEN_W:0]   rem;
    logic [31:0]      num;
    logic [15:0]      quo;
  } fpa_div_t;
endpackage

[src/fixed_point_atan2_core.sv]
// Fixed-point atan2 core: pipelined divider chain and cubic polynomial.
// One sample is accepted every cycle while the pipe advances; each sample passes through the front
// register, 32 division cells, 4 polynomial stages and the output register. The pipe
// advances whenever the output register is free or being emptied; a stalled output stalls
// the whole chain.
module fixed_point_atan2_core import fpa_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               valid_in,
  output logic               ready_in,
  input  logic signed [15:0] y_in,
  input  logic signed [15:0] x_in,
  input  logic               last_in,
  output logic               valid_out,
  input  logic               ready_out,
  output logic signed [15:0] angle,
  output logic               last_out
);
  localparam int unsigned NCELL = 32;
  localparam int unsigned NST = NCELL + 6;

  logic              en;
  logic [NST-1:0]    vld;
  fpa_div_t          front;
  fpa_div_t          chain [NCELL+1];

  assign en = !valid_out || ready_out;
  assign ready_in = en;

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (en) vld <= {vld[NST-2:0], valid_in};
  end
  assign valid_out = vld[NST-1];

  // front: magnitude, numerator and divisor
  logic [15:0] ay;
  logic signed [17:0] nn;
  logic [16:0] dd;
  always_comb begin
    if (y_in == -16'sd32768) ay = 16'd32767;
    else ay = y_in[15] ? 16'(-y_in) : 16'(y_in);
    if (!x_in[15]) begin
      nn = 18'(x_in) - 18'(signed'({1'b0, ay}));
      dd = 17'(signed'(x_in)) + {1'b0, ay};
    end else begin
      nn = 18'(x_in) + 18'(signed'({1'b0, ay}));
      dd = {1'b0, ay} - 17'(signed'(x_in));
    end
  end

  logic [17:0] nmag;
  always_comb nmag = nn[17] ? 18'(-nn) : 18'(nn);

  always_ff @(posedge clk) begin
    if (en) begin
      front.ctl <= '{last: last_in, zero: (dd == '0), x_neg: x_in[15],
                     y_neg: y_in[15], q_neg: nn[17]};
      front.den <= dd;
      front.rem <= '0;
      front.num <= {nmag[16:0], 15'd0};
      front.quo <= '0;
    end
  end

  assign chain[0] = front;

  for (genvar i = 0; i < NCELL; i++) begin : g_div
    fpa_div_cell u_cell (.clk(clk), .en(en), .d(chain[i]), .q(chain[i+1]));
  end

  // |ratio| <= 32768, which fits the low 16 quotient bits
  fpa_ctl_t c1, c2, c3, c4;
  logic signed [RW-1:0] r1, r2;
  logic signed [33:0]   sq;
  logic signed [33:0]   cu;
  logic signed [23:0]   lin, lin3;
  logic signed [24:0]   cub;
  logic [RW-1:0] rabs;

  always_comb begin
    rabs = {1'b0, chain[NCELL].quo};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c1 <= chain[NCELL].ctl;
      r1 <= chain[NCELL].ctl.q_neg ? -$signed(rabs) : $signed(rabs);
      c2 <= c1; r2 <= r1;
      sq <= 34'(r1) * 34'(r1);
      c3 <= c2;
      cu <= 34'(sq >>> 15) * 34'(r2);
      lin <= 24'(r2) * 24'(COEF_LIN);
      c4 <= c3;
      cub <= 25'(cu >>> 15) * 25'(COEF_CUB);
      lin3 <= lin;
    end
  end

  logic signed [25:0] sum;
  logic signed [15:0] p, a;
  always_comb begin
    sum = 26'(cub) + 26'(lin3);
    if ((sum >>> 10) > 26'sd32767) p = 16'sd32767;
    else if ((sum >>> 10) < -26'sd32768) p = -16'sd32768;
    else p = 16'(sum >>> 10);
    a = p + (c4.x_neg ? OFFSET_NEG : OFFSET_POS);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      angle <= c4.zero ? 16'sd0 : (c4.y_neg ? -a : a);
      last_out <= c4.last;
    end
  end

  assert property (@(posedge clk) disable iff (rst) valid_out && !ready_out |=> valid_out)
    else $error("result dropped");
  assert property (@(posedge clk) disable iff (rst) !ready_out && valid_out |-> !ready_in)
    else $error("input taken while chain stalled");
  assert property (@(posedge clk) disable iff (rst) valid_out && !ready_out |=> $stable(angle))
    else $error("angle changed while stalled");
endmodule

[src/fpa_div_cell.sv]
// One pipelined restoring-division cell: produces one quotient bit.
module fpa_div_cell import fpa_pkg::*; (
  input  logic     clk,
  input  logic     en,
  input  fpa_div_t d,
  output fpa_div_t q
);
  logic [DEN_W:0] shifted;
  logic [DEN_W:0] diff;
  logic           take;

  always_comb begin
    shifted = {d.rem[DEN_W-1:0], d.num[31]};
    diff    = shifted - {1'b0, d.den};
    take    = !diff[DEN_W];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q.ctl <= d.ctl;
      q.den <= d.den;
      q.rem <= take ? diff : shifted;
      q.num <= {d.num[30:0], 1'b0};
      q.quo <= {d.quo[14:0], take};
    end
  end
endmodule
